// ----- src/pfa_pkg.sv -----
package pfa_pkg;

  // Request operation codes.
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  // Fit policy codes; anything above worst fit is rejected.
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_NOFIT  = 3'd2,
    ST_FULL   = 3'd3,
    ST_BADPOL = 3'd4
  } pfa_status_t;

  // One request as it arrives.
  typedef struct packed {
    logic        operation;
    logic [1:0]  fit_policy;
    logic [15:0] process_id;
    logic [31:0] request_size;
    logic [31:0] block_start;
    logic [31:0] block_end;
  } pfa_req_t;

  // One result as it leaves.
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] granted_start;
    logic [31:0] granted_end;
    logic [15:0] granted_process;
    logic [4:0]  free_count;
  } pfa_rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        load;
    logic        append;
    logic        scan_start;
    logic        scan;
    logic        shift_start;
    logic        shift;
    logic        set_status;
    logic        grant;
    pfa_status_t code;
    logic        out_load;
  } pfa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_alloc;
    logic full;
    logic bad_policy;
    logic empty;
    logic scan_done;
    logic found;
    logic shift_done;
  } pfa_sts_t;

endpackage

// ----- src/pfa_datapath.sv -----
module pfa_datapath
  import pfa_pkg::*;
#(
  parameter int FREE_SLOTS = 16,
  parameter int ADDR_BITS  = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  pfa_req_t req_in,
  input  pfa_cmd_t cmd,
  output pfa_sts_t sts,
  output pfa_rsp_t rsp_out
);

  localparam int CW = $clog2(FREE_SLOTS + 1);
  localparam int IW = $clog2(FREE_SLOTS);
  localparam int DW = 2 * ADDR_BITS;

  // Partition table: start in the upper half of a word, end in the lower half.
  logic [DW-1:0]        mem [FREE_SLOTS];
  logic [DW-1:0]        rd_data;
  logic                 rd_vld;
  logic [IW-1:0]        rd_idx;

  pfa_req_t             req;
  logic [CW-1:0]        cnt;
  logic [CW-1:0]        ptr;

  logic                 found;
  logic [IW-1:0]        best_idx;
  logic [ADDR_BITS-1:0] best_slack;
  logic [ADDR_BITS-1:0] best_start;
  logic [ADDR_BITS-1:0] best_end;

  pfa_status_t          res_status;
  logic                 res_grant;

  logic [ADDR_BITS-1:0] rd_start;
  logic [ADDR_BITS-1:0] rd_end;
  logic [ADDR_BITS-1:0] slack;
  logic                 fits;
  logic                 better;
  logic                 take;
  logic                 stop;
  logic                 more;
  logic                 issue;
  logic                 wr_en;
  logic [IW-1:0]        wr_addr;
  logic [DW-1:0]        wr_data;

  // Fit test on the entry read in the previous cycle.
  assign rd_start = rd_data[DW-1:ADDR_BITS];
  assign rd_end   = rd_data[ADDR_BITS-1:0];
  assign slack    = rd_end - rd_start;
  assign fits     = (rd_end >= rd_start) && (32'(slack) >= req.request_size);
  assign better   = !found
                 || ((req.fit_policy == POL_BEST)  && (slack <= best_slack))
                 || ((req.fit_policy == POL_WORST) && (slack >= best_slack));
  assign take     = cmd.scan && rd_vld && fits && better;

  // First fit stops reading once it has a candidate.
  assign stop  = found && (req.fit_policy == POL_FIRST);
  assign more  = ptr < cnt;
  assign issue = (cmd.scan && more && !stop) || (cmd.shift && more);

  // Write port: append at the tail, or move an entry down one place.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt[IW-1:0];
    wr_data = {req.block_start[ADDR_BITS-1:0], req.block_end[ADDR_BITS-1:0]};
    if (cmd.append) begin
      wr_en = 1'b1;
    end else if (cmd.shift && rd_vld) begin
      wr_en   = 1'b1;
      wr_addr = rd_idx - IW'(1);
      wr_data = rd_data;
    end
  end

  // Table memory with a registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_data <= mem[ptr[IW-1:0]];
      rd_idx  <= ptr[IW-1:0];
    end
  end

  // Control registers: entry count, read-valid flag and found flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      rd_vld <= 1'b0;
      found  <= 1'b0;
    end else begin
      rd_vld <= issue;
      if (cmd.append) begin
        cnt <= cnt + CW'(1);
      end else if (cmd.grant) begin
        cnt <= cnt - CW'(1);
      end
      if (cmd.scan_start) begin
        found <= 1'b0;
      end else if (take) begin
        found <= 1'b1;
      end
    end
  end

  // Request capture, scan pointer, best candidate and pending result.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= req_in;
    end
    if (cmd.scan_start) begin
      ptr <= '0;
    end else if (cmd.shift_start) begin
      ptr <= CW'(best_idx) + CW'(1);
    end else if (issue) begin
      ptr <= ptr + CW'(1);
    end
    if (take) begin
      best_idx   <= rd_idx;
      best_slack <= slack;
      best_start <= rd_start;
      best_end   <= rd_end;
    end
    if (cmd.set_status) begin
      res_status <= cmd.code;
      res_grant  <= cmd.grant;
    end
  end

  // Output register; the count is taken after the table has been updated.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp_out.status          <= res_status;
      rsp_out.granted_start   <= res_grant ? 32'(best_start) : '0;
      rsp_out.granted_end     <= res_grant ? 32'(best_end) : '0;
      rsp_out.granted_process <= res_grant ? req.process_id : '0;
      rsp_out.free_count      <= 5'(cnt);
    end
  end

  // Status towards the controller.
  always_comb begin
    sts.is_alloc   = (req.operation == OP_ALLOC);
    sts.full       = (cnt >= CW'(FREE_SLOTS));
    sts.bad_policy = (req.fit_policy > POL_WORST);
    sts.empty      = (cnt == '0);
    sts.scan_done  = (!more || stop) && !rd_vld;
    sts.found      = found;
    sts.shift_done = !more && !rd_vld;
  end

endmodule

// ----- src/pfa_ctrl.sv -----
module pfa_ctrl
  import pfa_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  input  pfa_sts_t sts,
  output pfa_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_SHIFT,
    S_PUSH
  } state_t;

  state_t state;
  state_t state_next;
  logic   can_push;

  assign req_ready = (state == S_IDLE);
  assign can_push  = !rsp_valid || rsp_ready;

  // Command decode and next state.
  always_comb begin
    cmd        = '0;
    cmd.code   = ST_OK;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.set_status = 1'b1;
        state_next     = S_PUSH;
        if (!sts.is_alloc) begin
          if (sts.full) begin
            cmd.code = ST_FULL;
          end else begin
            cmd.append = 1'b1;
          end
        end else if (sts.bad_policy) begin
          cmd.code = ST_BADPOL;
        end else if (sts.empty) begin
          cmd.code = ST_EMPTY;
        end else begin
          cmd.set_status = 1'b0;
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          if (sts.found) begin
            cmd.shift_start = 1'b1;
            state_next      = S_SHIFT;
          end else begin
            cmd.set_status = 1'b1;
            cmd.code       = ST_NOFIT;
            state_next     = S_PUSH;
          end
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (sts.shift_done) begin
          cmd.set_status = 1'b1;
          cmd.grant      = 1'b1;
          cmd.code       = ST_OK;
          state_next     = S_PUSH;
        end
      end
      S_PUSH: begin
        if (can_push) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and result-valid register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_PUSH && can_push) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- src/partition_fit_allocator.sv -----
// Free-partition allocator. Up to FREE_SLOTS free partitions are held in order
// in a single-port-read table memory. An add request appends a partition, or
// reports a full table. An allocate request scans the table one entry per
// cycle through the memory's read port, then closes the gap left by the
// granted partition by moving each later entry down one place, again one per
// cycle. First fit ends the scan at the first fitting entry. Requests are
// taken one at a time, and the next request is accepted while a result still
// waits in the output register, which holds it until the result is taken.
module partition_fit_allocator
  import pfa_pkg::*;
#(
  parameter int FREE_SLOTS = 16,
  parameter int ADDR_BITS  = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  pfa_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output pfa_rsp_t rsp
);

  pfa_cmd_t cmd;
  pfa_sts_t sts;

  // Sequencing of each request.
  pfa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Table, fit comparison and result register.
  pfa_datapath #(
    .FREE_SLOTS (FREE_SLOTS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .req_in  (req),
    .cmd     (cmd),
    .sts     (sts),
    .rsp_out (rsp)
  );

endmodule
